>>> rtl/core/merge_sort_engine_macros.svh
// ----------------------------------------------------------------------------
// merge_sort_engine_macros.svh
// Assertion macros for the merge sort engine. They compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef MERGE_SORT_ENGINE_MACROS_SVH
`define MERGE_SORT_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MSE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mse assertion failed");
// next-cycle implication
`define MSE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mse assertion failed");
`else
`define MSE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MSE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/core/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared sizes and types of the merge sort engine.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int DATA_W    = 32;
  localparam int MAX_ELEMS = 32;
  localparam int IDX_W     = $clog2(MAX_ELEMS);
  localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
  localparam int BND_W     = CNT_W + 1;

  // one store's port requests for a cycle
  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]         raddr0;
    logic [IDX_W-1:0]         raddr1;
  } ram_req_t;

endpackage

>>> rtl/core/merge_sort_engine.sv
// ----------------------------------------------------------------------------
// merge_sort_engine
// Load: one cycle per value while busy_o is low; extra values set overflow.
// Sort of n values: ceil(log2 n) merge passes; each pass reads, compares (one
// shared comparator) and writes each value, with a setup step per merged pair.
// Output: each result is read, then shown, so results never come back to back;
// the receiver cannot stall.
// Reset (async, active low) empties the set and returns to loading.
// ----------------------------------------------------------------------------
`include "merge_sort_engine_macros.svh"

module merge_sort_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [mse_pkg::DATA_W-1:0] value_in_i,
  input  logic                              last_in_i,
  output logic                              valid_o,
  output logic signed [mse_pkg::DATA_W-1:0] value_out_o,
  output logic                              last_out_o,
  output logic                              overflow_o
);
  import mse_pkg::*;

  ram_req_t                 req_a;
  ram_req_t                 req_b;
  logic signed [DATA_W-1:0] rdata_a0;
  logic signed [DATA_W-1:0] rdata_a1;
  logic signed [DATA_W-1:0] rdata_b0;
  logic signed [DATA_W-1:0] rdata_b1;

  mse_ram u_store_a (
    .clk_i    (clk_i),
    .req_i    (req_a),
    .rdata0_o (rdata_a0),
    .rdata1_o (rdata_a1)
  );

  mse_ram u_store_b (
    .clk_i    (clk_i),
    .req_i    (req_b),
    .rdata0_o (rdata_b0),
    .rdata1_o (rdata_b1)
  );

  mse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .value_in_i  (value_in_i),
    .last_in_i   (last_in_i),
    .valid_o     (valid_o),
    .value_out_o (value_out_o),
    .last_out_o  (last_out_o),
    .overflow_o  (overflow_o),
    .req_a_o     (req_a),
    .req_b_o     (req_b),
    .rdata_a0_i  (rdata_a0),
    .rdata_a1_i  (rdata_a1),
    .rdata_b0_i  (rdata_b0),
    .rdata_b1_i  (rdata_b1)
  );

  // results only come out of a sort in progress
  `MSE_ASSERT_IMP(a_valid_busy, clk_i, rst_ni, valid_o, busy_o)
  `MSE_ASSERT_IMP(a_last_valid, clk_i, rst_ni, last_out_o, valid_o)
  // after the final result the engine is idle again
  `MSE_ASSERT_NXT(a_last_idle, clk_i, rst_ni, valid_o && last_out_o, !busy_o && !valid_o)
  // a closing transfer always starts the sort
  `MSE_ASSERT_NXT(a_close_busy, clk_i, rst_ni, start_i && !busy_o && last_in_i, busy_o)
  // results never come back to back
  `MSE_ASSERT_NXT(a_out_gap, clk_i, rst_ni, valid_o, !valid_o)

endmodule

>>> rtl/core/mse_ram.sv
// ----------------------------------------------------------------------------
// mse_ram
// Element store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module mse_ram (
  input  logic                             clk_i,
  input  mse_pkg::ram_req_t                req_i,
  output logic signed [mse_pkg::DATA_W-1:0] rdata0_o,
  output logic signed [mse_pkg::DATA_W-1:0] rdata1_o
);
  import mse_pkg::*;

  logic signed [DATA_W-1:0] mem_q [MAX_ELEMS];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata0_o <= mem_q[req_i.raddr0];
    rdata1_o <= mem_q[req_i.raddr1];
  end

endmodule

>>> rtl/core/mse_ctrl.sv
// ----------------------------------------------------------------------------
// mse_ctrl
// Sequencer of the engine: loads the set, runs the bottom-up merge passes with
// one shared compare unit, then streams the sorted set out.
// ----------------------------------------------------------------------------
module mse_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [mse_pkg::DATA_W-1:0] value_in_i,
  input  logic                              last_in_i,
  output logic                              valid_o,
  output logic signed [mse_pkg::DATA_W-1:0] value_out_o,
  output logic                              last_out_o,
  output logic                              overflow_o,
  output mse_pkg::ram_req_t                 req_a_o,
  output mse_pkg::ram_req_t                 req_b_o,
  input  logic signed [mse_pkg::DATA_W-1:0] rdata_a0_i,
  input  logic signed [mse_pkg::DATA_W-1:0] rdata_a1_i,
  input  logic signed [mse_pkg::DATA_W-1:0] rdata_b0_i,
  input  logic signed [mse_pkg::DATA_W-1:0] rdata_b1_i
);
  import mse_pkg::*;

  localparam logic [2:0] S_LOAD     = 3'd0;
  localparam logic [2:0] S_SETUP    = 3'd1;
  localparam logic [2:0] S_RD       = 3'd2;
  localparam logic [2:0] S_WR       = 3'd3;
  localparam logic [2:0] S_EMIT_RD  = 3'd4;
  localparam logic [2:0] S_EMIT_OUT = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             src_sel_q, src_sel_d;   // 0: store A holds the source run
  logic [CNT_W-1:0] width_q, width_d;
  logic [CNT_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0] mid_q, mid_d;
  logic [CNT_W-1:0] hi_q, hi_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [CNT_W-1:0] k_q, k_d;

  logic                     accept;
  logic                     room;
  logic [CNT_W-1:0]         n_new;
  logic [BND_W-1:0]         w2;
  logic [BND_W-1:0]         lo_w;
  logic [BND_W-1:0]         lo_2w;
  logic [BND_W-1:0]         n_ext;
  logic [CNT_W-1:0]         k_n;
  logic signed [DATA_W-1:0] src0;
  logic signed [DATA_W-1:0] src1;
  logic                     take_r;
  logic                     we;
  logic                     we_to_a;
  logic [IDX_W-1:0]         waddr;
  logic signed [DATA_W-1:0] wdata;
  logic [IDX_W-1:0]         raddr0;
  logic [IDX_W-1:0]         raddr1;

  assign accept = start_i && (state_q == S_LOAD);
  assign room   = count_q < CNT_W'(MAX_ELEMS);
  assign n_new  = room ? count_q + 1'b1 : count_q;
  assign w2     = {1'b0, width_q} << 1;
  assign lo_w   = {1'b0, lo_q} + {1'b0, width_q};
  assign lo_2w  = {1'b0, lo_q} + w2;
  assign n_ext  = {1'b0, count_q};
  assign k_n    = k_q + 1'b1;
  assign src0   = src_sel_q ? rdata_b0_i : rdata_a0_i;
  assign src1   = src_sel_q ? rdata_b1_i : rdata_a1_i;

  // shared compare: right run wins if the left run is used up or right is strictly smaller (stable merge)
  assign take_r = (j_q < hi_q) && ((i_q >= mid_q) || (src1 < src0));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    src_sel_d = src_sel_q;
    width_d   = width_q;
    lo_d      = lo_q;
    mid_d     = mid_q;
    hi_d      = hi_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    we        = 1'b0;
    we_to_a   = 1'b0;
    waddr     = k_q[IDX_W-1:0];
    wdata     = take_r ? src1 : src0;
    raddr0    = i_q[IDX_W-1:0];
    raddr1    = j_q[IDX_W-1:0];
    valid_o   = 1'b0;
    last_out_o = 1'b0;

    case (state_q)
      S_LOAD: begin
        waddr = count_q[IDX_W-1:0];
        wdata = value_in_i;
        if (accept) begin
          if (room) begin
            we      = 1'b1;
            we_to_a = 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          count_d = n_new;
          if (last_in_i) begin
            src_sel_d = 1'b0;
            width_d   = CNT_W'(1);
            lo_d      = '0;
            k_d       = '0;
            state_d   = (n_new > CNT_W'(1)) ? S_SETUP : S_EMIT_RD;
          end
        end
      end
      S_SETUP: begin
        mid_d   = (lo_w < n_ext) ? lo_w[CNT_W-1:0] : count_q;
        hi_d    = (lo_2w < n_ext) ? lo_2w[CNT_W-1:0] : count_q;
        i_d     = lo_q;
        j_d     = (lo_w < n_ext) ? lo_w[CNT_W-1:0] : count_q;
        k_d     = lo_q;
        state_d = S_RD;
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        we      = 1'b1;
        we_to_a = src_sel_q;
        k_d     = k_n;
        if (take_r) begin
          j_d = j_q + 1'b1;
        end else begin
          i_d = i_q + 1'b1;
        end
        if (k_n == hi_q) begin
          if (hi_q == count_q) begin
            // pass done: stores swap roles
            src_sel_d = ~src_sel_q;
            lo_d      = '0;
            if (w2 >= n_ext) begin
              k_d     = '0;
              state_d = S_EMIT_RD;
            end else begin
              width_d = w2[CNT_W-1:0];
              state_d = S_SETUP;
            end
          end else begin
            lo_d    = hi_q;
            state_d = S_SETUP;
          end
        end else begin
          state_d = S_RD;
        end
      end
      S_EMIT_RD: begin
        raddr0  = k_q[IDX_W-1:0];
        state_d = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        raddr0     = k_q[IDX_W-1:0];
        valid_o    = 1'b1;
        last_out_o = (k_n == count_q);
        if (k_n == count_q) begin
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = S_LOAD;
        end else begin
          k_d     = k_n;
          state_d = S_EMIT_RD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  assign busy_o      = (state_q != S_LOAD);
  assign value_out_o = src0;
  assign overflow_o  = ovf_q;

  always_comb begin
    req_a_o.we     = we && we_to_a;
    req_a_o.waddr  = waddr;
    req_a_o.wdata  = wdata;
    req_a_o.raddr0 = raddr0;
    req_a_o.raddr1 = raddr1;
    req_b_o.we     = we && !we_to_a;
    req_b_o.waddr  = waddr;
    req_b_o.wdata  = wdata;
    req_b_o.raddr0 = raddr0;
    req_b_o.raddr1 = raddr1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      src_sel_q <= 1'b0;
      width_q   <= '0;
      lo_q      <= '0;
      mid_q     <= '0;
      hi_q      <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      src_sel_q <= src_sel_d;
      width_q   <= width_d;
      lo_q      <= lo_d;
      mid_q     <= mid_d;
      hi_q      <= hi_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
    end
  end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Feeds sets of signed words into merge_sort_engine and checks the sorted
// stream against an in-bench model that keeps each open set in sorted order.
// Directed table first, then random sets of mixed sizes including full and
// overflowing sets, with random sender gaps and at times a drain pause between sets.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic signed [mse_pkg::DATA_W-1:0] word_t;

  typedef struct packed {
    word_t value;
    logic  last;
    logic  ovf;
  } sorted_word_t;

  // directed stimulus; n_typed > 0 means the expected results are typed in
  typedef struct packed {
    word_t      value;
    logic       last;
    logic [1:0] n_typed;
    word_t      typed_lo;
    word_t      typed_hi;
  } stim_row_t;

  localparam int    N_ROWS      = 22;
  localparam int    STALL_LIMIT = 4000;
  localparam int    RAND_ITEMS  = 300;
  localparam word_t W_MAX       = 32'sh7fff_ffff;
  localparam word_t W_MIN       = 32'sh8000_0000;

  localparam stim_row_t DIR_TAB [N_ROWS] = '{
    '{32'sd0,   1'b1, 2'd1, 32'sd0,   32'sd0},
    '{-32'sd1,  1'b1, 2'd1, -32'sd1,  32'sd0},
    '{W_MAX,    1'b1, 2'd1, W_MAX,    32'sd0},
    '{W_MIN,    1'b1, 2'd1, W_MIN,    32'sd0},
    '{W_MAX,    1'b0, 2'd0, 32'sd0,   32'sd0},
    '{W_MIN,    1'b1, 2'd2, W_MIN,    W_MAX},
    '{W_MIN,    1'b0, 2'd0, 32'sd0,   32'sd0},
    '{W_MAX,    1'b1, 2'd2, W_MIN,    W_MAX},
    // ties
    '{32'sd5,   1'b0, 2'd0, 32'sd0,   32'sd0},
    '{32'sd5,   1'b0, 2'd0, 32'sd0,   32'sd0},
    '{-32'sd5,  1'b1, 2'd0, 32'sd0,   32'sd0},
    // reverse order
    '{32'sd7,   1'b0, 2'd0, 32'sd0,   32'sd0},
    '{32'sd6,   1'b0, 2'd0, 32'sd0,   32'sd0},
    '{32'sd5,   1'b0, 2'd0, 32'sd0,   32'sd0},
    '{32'sd4,   1'b0, 2'd0, 32'sd0,   32'sd0},
    '{32'sd3,   1'b0, 2'd0, 32'sd0,   32'sd0},
    '{32'sd2,   1'b0, 2'd0, 32'sd0,   32'sd0},
    '{32'sd1,   1'b1, 2'd0, 32'sd0,   32'sd0},
    '{32'sh5555_5555, 1'b0, 2'd0, 32'sd0, 32'sd0},
    '{32'shaaaa_aaaa, 1'b0, 2'd0, 32'sd0, 32'sd0},
    '{32'sd1,   1'b0, 2'd0, 32'sd0,   32'sd0},
    '{-32'sd2,  1'b1, 2'd0, 32'sd0,   32'sd0}
  };

  logic  clk_i;
  logic  rst_ni;
  logic  start_i;
  logic  busy_o;
  word_t value_in_i;
  logic  last_in_i;
  logic  valid_o;
  word_t value_out_o;
  logic  last_out_o;
  logic  overflow_o;

  merge_sort_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .value_in_i  (value_in_i),
    .last_in_i   (last_in_i),
    .valid_o     (valid_o),
    .value_out_o (value_out_o),
    .last_out_o  (last_out_o),
    .overflow_o  (overflow_o)
  );

  // open set, kept sorted on insertion (stable: equal values stay in order)
  word_t        held_vals_q[$];
  logic         held_ovf;
  sorted_word_t fresh_q[$];
  sorted_word_t pending_sorted_q[$];
  int           mismatches;
  int           stall_cycles;
  bit           no_gaps;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  task automatic absorb_value(input word_t v, input logic l);
    int pos;
    int n;
    pos = held_vals_q.size();
    if (pos < mse_pkg::MAX_ELEMS) begin
      while (pos > 0 && held_vals_q[pos-1] > v) pos--;
      held_vals_q.insert(pos, v);
    end else begin
      held_ovf = 1'b1;
    end
    fresh_q.delete();
    if (l) begin
      n = held_vals_q.size();
      for (int k = 0; k < n; k++)
        fresh_q.push_back('{held_vals_q[k], (k == n - 1), held_ovf});
      held_vals_q.delete();
      held_ovf = 1'b0;
    end
  endtask

  task automatic send_value(input word_t v, input logic l, input logic [1:0] n_typed,
                            input word_t typed_lo, input word_t typed_hi);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    value_in_i <= v;
    last_in_i  <= l;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    // transfer taken at this edge
    absorb_value(v, l);
    if (n_typed == 2'd1) begin
      pending_sorted_q.push_back('{typed_lo, 1'b1, 1'b0});
    end else if (n_typed == 2'd2) begin
      pending_sorted_q.push_back('{typed_lo, 1'b0, 1'b0});
      pending_sorted_q.push_back('{typed_hi, 1'b1, 1'b0});
    end else begin
      foreach (fresh_q[k]) pending_sorted_q.push_back(fresh_q[k]);
    end
  endtask

  task automatic drain_pause();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_sorted_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic word_t draw_word(int mode);
    int pick;
    case (mode)
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(0, 8)) - 32'sd4;
      default: begin
        pick = $urandom_range(0, 5);
        case (pick)
          0: return W_MAX;
          1: return W_MIN;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return word_t'($urandom);
        endcase
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    sorted_word_t want;
    if (rst_ni && valid_o) begin
      if (pending_sorted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d last %0b ovf %0b",
                   value_out_o, last_out_o, overflow_o);
      end else begin
        want = pending_sorted_q.pop_front();
        if (value_out_o !== want.value || last_out_o !== want.last ||
            overflow_o !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp value %0d last %0b ovf %0b, got %0d %0b %0b",
                     want.value, want.last, want.ovf,
                     value_out_o, last_out_o, overflow_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int   sent;
    int   set_idx;
    int   set_len;
    int   size_pick;
    int   mode;
    logic closing;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    value_in_i   = '0;
    last_in_i    = 1'b0;
    held_ovf     = 1'b0;
    no_gaps      = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < N_ROWS; r++)
      send_value(DIR_TAB[r].value, DIR_TAB[r].last, DIR_TAB[r].n_typed,
                 DIR_TAB[r].typed_lo, DIR_TAB[r].typed_hi);
    drain_pause();

    sent    = 0;
    set_idx = 0;
    while (sent < RAND_ITEMS) begin
      size_pick = $urandom_range(0, 99);
      // first sets: one overflowing, one exactly full
      if (set_idx == 0 || size_pick >= 90)
        set_len = mse_pkg::MAX_ELEMS + $urandom_range(1, 6);
      else if (set_idx == 1 || size_pick >= 78)
        set_len = mse_pkg::MAX_ELEMS;
      else if (size_pick >= 58)
        set_len = $urandom_range(7, mse_pkg::MAX_ELEMS - 1);
      else
        set_len = $urandom_range(1, 6);
      mode    = $urandom_range(0, 2);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < set_len; k++) begin
        closing = (k == set_len - 1);
        send_value(draw_word(mode), closing, 2'd0, 32'sd0, 32'sd0);
        sent++;
      end
      if ($urandom_range(0, 5) == 0) drain_pause();
      set_idx++;
    end

    start_i <= 1'b0;
    while (pending_sorted_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
